@@ hdl/usart_register_block_core_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef USART_REGISTER_BLOCK_CORE_ASSERT_SVH
`define USART_REGISTER_BLOCK_CORE_ASSERT_SVH

// Checked at every edge outside reset.
`define URB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define URB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/urb_pkg.sv @@
// ----------------------------------------------------------------------------
// urb_pkg
// Types, codes and helpers of the USART register block.
// ----------------------------------------------------------------------------
package urb_pkg;

    localparam int FRAME_W = 27;

    // request functions
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;
    localparam logic [1:0] FUNC_ACK   = 2'd3;

    // register offsets
    localparam logic [2:0] ADDR_DATA   = 3'd0;
    localparam logic [2:0] ADDR_STATUS = 3'd1;
    localparam logic [2:0] ADDR_CTRLA  = 3'd3;
    localparam logic [2:0] ADDR_CTRLB  = 3'd4;
    localparam logic [2:0] ADDR_CTRLC  = 3'd5;
    localparam logic [2:0] ADDR_BAUDA  = 3'd6;
    localparam logic [2:0] ADDR_BAUDB  = 3'd7;

    // STATUS bits
    localparam int ST_RXCIF  = 7;
    localparam int ST_TXCIF  = 6;
    localparam int ST_DREIF  = 5;
    localparam int ST_BUFOVF = 3;
    localparam int ST_RXB8   = 0;
    localparam logic [7:0] STATUS_RESET = 8'h20;

    // CTRLB bits
    localparam int CB_RXEN  = 4;
    localparam int CB_TXEN  = 3;
    localparam int CB_CLK2X = 2;
    localparam int CB_TXB8  = 0;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] address;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [8:0] rx_data;
        logic       tx_ready;
    } urb_req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [8:0] tx_data;
        logic       rx_taken;
        logic [1:0] irq_rxc_level;
        logic [1:0] irq_txc_level;
        logic [1:0] irq_dre_level;
    } urb_rsp_t;

    // configuration that sets the frame time
    typedef struct packed {
        logic [4:0]  ctrl_b;
        logic [7:0]  ctrl_c;
        logic [11:0] baud_select;
        logic [3:0]  baud_scale;
    } urb_cfg_t;

    // mask of the data bits for a CHSIZE code
    function automatic logic [8:0] data_mask(input logic [2:0] chsize);
        logic [8:0] m;
        unique case (chsize)
            3'd0:    m = 9'h01F;
            3'd1:    m = 9'h03F;
            3'd2:    m = 9'h07F;
            3'd3:    m = 9'h0FF;
            default: m = 9'h1FF;
        endcase
        return m;
    endfunction

endpackage

@@ hdl/urb_frame_calc.sv @@
// ----------------------------------------------------------------------------
// urb_frame_calc
// Frame time in peripheral ticks: frame bits times oversampled bit time.
// ----------------------------------------------------------------------------
module urb_frame_calc (
    input  urb_pkg::urb_cfg_t              cfg,
    output logic [urb_pkg::FRAME_W-1:0]    frame_ticks
);
    import urb_pkg::*;

    logic [2:0]  chsize;
    logic [3:0]  data_bits;
    logic [3:0]  bits_per_frame;
    logic [2:0]  neg_shift;
    logic [19:0] per_bit;
    logic [23:0] per_bit_os;
    logic [27:0] product;

    assign chsize = cfg.ctrl_c[2:0];

    always_comb
    begin
        data_bits  = (chsize == 3'd7) ? 4'd9 : ({1'b0, chsize} + 4'd5);
        bits_per_frame = 4'd1 + data_bits + {3'd0, (cfg.ctrl_c[5:4] != 2'd0)}
                         + (cfg.ctrl_c[3] ? 4'd2 : 4'd1);
        neg_shift  = 3'd0 - cfg.baud_scale[2:0];
        if (!cfg.baud_scale[3])
        begin
            per_bit = ({8'd0, cfg.baud_select} + 20'd1) << cfg.baud_scale[2:0];
        end
        else
        begin
            per_bit = {8'd0, (cfg.baud_select >> neg_shift)} + 20'd1;
        end
        per_bit_os = cfg.ctrl_b[CB_CLK2X] ? {1'b0, per_bit, 3'd0} : {per_bit, 4'd0};
        product    = {24'd0, bits_per_frame} * {4'd0, per_bit_os};
    end

    assign frame_ticks = product[FRAME_W-1:0];

endmodule

@@ hdl/urb_regs.sv @@
// ----------------------------------------------------------------------------
// urb_regs
// Register file, flags and frame countdowns; one request per step.
// ----------------------------------------------------------------------------
module urb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  urb_pkg::urb_req_t              item,
    input  logic [urb_pkg::FRAME_W-1:0]    frame_ticks,
    output urb_pkg::urb_cfg_t              cfg,
    output urb_pkg::urb_rsp_t              rsp_next
);
    import urb_pkg::*;

    logic [7:0]         status_reg,   status_next;
    logic [4:0]         ctrl_b_reg,   ctrl_b_next;
    logic [7:0]         ctrl_c_reg,   ctrl_c_next;
    logic [5:0]         levels_reg,   levels_next;
    logic [11:0]        bsel_reg,     bsel_next;
    logic [3:0]         bscale_reg,   bscale_next;
    logic [7:0]         rx_buf_reg,   rx_buf_next;
    logic [7:0]         tx_buf_reg,   tx_buf_next;
    logic [FRAME_W-1:0] rx_wait_reg,  rx_wait_next;
    logic [FRAME_W-1:0] tx_wait_reg,  tx_wait_next;

    logic [8:0]  mask;
    logic [8:0]  rx_char;
    logic [2:0]  cs_clean;
    logic [1:0]  pm_clean;
    logic [3:0]  sc_clean;
    logic [11:0] bsel_new;

    assign mask    = data_mask(ctrl_c_reg[2:0]);
    assign rx_char = item.rx_data & mask;

    assign cfg.ctrl_b      = ctrl_b_reg;
    assign cfg.ctrl_c      = ctrl_c_reg;
    assign cfg.baud_select = bsel_reg;
    assign cfg.baud_scale  = bscale_reg;

    always_comb
    begin
        status_next  = status_reg;
        ctrl_b_next  = ctrl_b_reg;
        ctrl_c_next  = ctrl_c_reg;
        levels_next  = levels_reg;
        bsel_next    = bsel_reg;
        bscale_next  = bscale_reg;
        rx_buf_next  = rx_buf_reg;
        tx_buf_next  = tx_buf_reg;
        rx_wait_next = rx_wait_reg;
        tx_wait_next = tx_wait_reg;
        rsp_next     = '0;

        // CTRLC clean-up: CMODE forced to async, reserved sizes and PMODE 1 dropped
        cs_clean = item.write_data[2:0];
        if (cs_clean > 3'd3 && cs_clean != 3'd7)
        begin
            cs_clean = 3'd3;
        end
        pm_clean = (item.write_data[5:4] == 2'd1) ? 2'd0 : item.write_data[5:4];
        sc_clean = (item.write_data[3:0] == 4'h8) ? 4'h0 : item.write_data[3:0];
        bsel_new = '0;

        unique case (item.func)
            FUNC_READ:
            begin
                unique case (item.address)
                    ADDR_DATA:
                    begin
                        rsp_next.read_data        = rx_buf_reg;
                        status_next[ST_RXCIF]     = 1'b0;
                        status_next[ST_BUFOVF]    = 1'b0;
                    end
                    ADDR_STATUS: rsp_next.read_data = status_reg;
                    ADDR_CTRLA:  rsp_next.read_data = {2'd0, levels_reg};
                    ADDR_CTRLB:  rsp_next.read_data = {3'd0, ctrl_b_reg};
                    ADDR_CTRLC:  rsp_next.read_data = ctrl_c_reg;
                    ADDR_BAUDA:  rsp_next.read_data = bsel_reg[7:0];
                    ADDR_BAUDB:  rsp_next.read_data = {bsel_reg[11:8], bscale_reg};
                    default:     rsp_next.read_data = 8'd0;
                endcase
            end
            FUNC_WRITE:
            begin
                unique case (item.address)
                    ADDR_DATA:
                    begin
                        if (status_reg[ST_DREIF])
                        begin
                            tx_buf_next           = item.write_data;
                            status_next[ST_DREIF] = 1'b0;
                        end
                    end
                    ADDR_STATUS:
                    begin
                        status_next[ST_RXB8] = item.write_data[ST_RXB8];
                        if (item.write_data[ST_TXCIF])
                        begin
                            status_next[ST_TXCIF] = 1'b0;
                        end
                        if (item.write_data[ST_RXCIF])
                        begin
                            status_next[ST_RXCIF] = 1'b0;
                        end
                    end
                    ADDR_CTRLA: levels_next = item.write_data[5:0];
                    ADDR_CTRLB: ctrl_b_next = item.write_data[4:0];
                    ADDR_CTRLC: ctrl_c_next = {2'd0, pm_clean, item.write_data[3], cs_clean};
                    ADDR_BAUDA:
                    begin
                        bsel_new  = {bsel_reg[11:8], item.write_data};
                        bsel_next = bsel_new;
                        if (bsel_new == 12'd0)
                        begin
                            bscale_next = 4'd0;
                        end
                    end
                    ADDR_BAUDB:
                    begin
                        bsel_new    = {item.write_data[7:4], bsel_reg[7:0]};
                        bsel_next   = bsel_new;
                        bscale_next = (bsel_new == 12'd0) ? 4'd0 : sc_clean;
                    end
                    default: ;
                endcase
            end
            FUNC_TICK:
            begin
                if (rx_wait_reg != '0)
                begin
                    rx_wait_next = rx_wait_reg - FRAME_W'(1);
                end
                if (tx_wait_reg != '0)
                begin
                    tx_wait_next = tx_wait_reg - FRAME_W'(1);
                end
                if (ctrl_b_reg[CB_RXEN] && rx_wait_next == '0 && item.rx_valid)
                begin
                    rsp_next.rx_taken = 1'b1;
                    rx_wait_next      = frame_ticks;
                    if (status_reg[ST_RXCIF])
                    begin
                        status_next[ST_BUFOVF] = 1'b1;
                    end
                    else
                    begin
                        rx_buf_next           = rx_char[7:0];
                        status_next[ST_RXB8]  = rx_char[8];
                        status_next[ST_RXCIF] = 1'b1;
                    end
                end
                if (ctrl_b_reg[CB_TXEN] && !status_reg[ST_DREIF] &&
                    tx_wait_next == '0 && item.tx_ready)
                begin
                    rsp_next.tx_valid     = 1'b1;
                    rsp_next.tx_data      = {ctrl_b_reg[CB_TXB8], tx_buf_reg} & mask;
                    tx_wait_next          = frame_ticks;
                    status_next[ST_DREIF] = 1'b1;
                    status_next[ST_TXCIF] = 1'b1;
                end
            end
            FUNC_ACK:
            begin
                status_next[ST_TXCIF] = 1'b0;
            end
            default: ;
        endcase

        rsp_next.irq_rxc_level = status_next[ST_RXCIF] ? levels_next[5:4] : 2'd0;
        rsp_next.irq_txc_level = status_next[ST_TXCIF] ? levels_next[3:2] : 2'd0;
        rsp_next.irq_dre_level = status_next[ST_DREIF] ? levels_next[1:0] : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= STATUS_RESET;
            ctrl_b_reg  <= '0;
            ctrl_c_reg  <= '0;
            levels_reg  <= '0;
            bsel_reg    <= '0;
            bscale_reg  <= '0;
            rx_buf_reg  <= '0;
            tx_buf_reg  <= '0;
            rx_wait_reg <= '0;
            tx_wait_reg <= '0;
        end
        else if (step)
        begin
            status_reg  <= status_next;
            ctrl_b_reg  <= ctrl_b_next;
            ctrl_c_reg  <= ctrl_c_next;
            levels_reg  <= levels_next;
            bsel_reg    <= bsel_next;
            bscale_reg  <= bscale_next;
            rx_buf_reg  <= rx_buf_next;
            tx_buf_reg  <= tx_buf_next;
            rx_wait_reg <= rx_wait_next;
            tx_wait_reg <= tx_wait_next;
        end
    end

endmodule

@@ hdl/usart_register_block_core.sv @@
// ----------------------------------------------------------------------------
// usart_register_block_core
// Asynchronous USART register block with registered request and result.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid / req_stall / req) carries one bus read, bus
//   write, peripheral clock tick or TXC acknowledge per request. Result
//   channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   request, in order: read data, transmitted character, receive-consumed
//   flag and the three interrupt levels.
//   A request is held in the request register, then its result in the
//   result register (two register stages).
//   Throughput: one request per cycle while no result is stalled; the
//   register update and frame-time multiply (4 x 24 bit) sit between stages.
//   Stall: while rsp_stall holds a pending result, the request register
//   keeps its request and req_stall rises only if that register is full,
//   so one more request is taken while a result waits.
//   Reset: rst_n clears both stages and puts the register file in its
//   reset state (STATUS = DRE set, everything else zero, frame = 112).
// ----------------------------------------------------------------------------
module usart_register_block_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  urb_pkg::urb_req_t  req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output urb_pkg::urb_rsp_t  rsp
);
    import urb_pkg::*;

    urb_req_t           req_reg;
    logic               req_valid_reg;
    urb_rsp_t           rsp_reg;
    logic               rsp_valid_reg;
    urb_rsp_t           rsp_next;
    urb_cfg_t           cfg;
    logic [FRAME_W-1:0] frame_ticks;
    logic               advance;
    logic               step;

    // result register free or being drained this cycle
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign step      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;

    // frame time follows the live configuration registers
    urb_frame_calc u_frame_calc (
        .cfg         (cfg),
        .frame_ticks (frame_ticks)
    );

    urb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (req_reg),
        .frame_ticks (frame_ticks),
        .cfg         (cfg),
        .rsp_next    (rsp_next)
    );

    // request register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (!req_stall)
        begin
            req_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            req_reg <= req;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hdl/urb_checker.sv @@
// ----------------------------------------------------------------------------
// urb_checker
// Port-level checks of the USART register block, bound to the top level.
// ----------------------------------------------------------------------------
`include "usart_register_block_core_assert.svh"

module urb_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  urb_pkg::urb_rsp_t  rsp
);
    import urb_pkg::*;

    // held result stays put
    `URB_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "result changed while stalled")

    // every accepted request leads to a valid result
    `URB_ASSERT(a_latency, req_valid && !req_stall |-> ##2 rsp_valid, "result missing after request")

    // no character means no character data
    `URB_ASSERT(a_tx_data, rsp_valid && !rsp.tx_valid |-> rsp.tx_data == 9'd0, "tx_data without tx_valid")

    // link activity only on ticks, which return no read data
    `URB_ASSERT(a_tick_read, rsp_valid && (rsp.tx_valid || rsp.rx_taken) |-> rsp.read_data == 8'd0, "read data on a tick")

    // reset seen at an edge leaves the result stage empty at the next one
    `URB_ASSERT_ALWAYS(a_reset, !rst_n |=> !rsp_valid, "result valid after reset")

endmodule

bind usart_register_block_core urb_checker u_checker (.*);
